FILE: rtl/core/cshl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cshl_pkg
// Shared types, widths and reset constants of the channel scan hit logger.
// ----------------------------------------------------------------------------
package cshl_pkg;

    localparam int TIME_W = 32;
    localparam int CH_W   = 7;
    localparam int CFG_W  = 16;
    localparam int CNT_W  = 8;
    localparam int IDX_W  = 2;

    localparam int TABLE_DEPTH_DEF = 128;
    localparam int MAX_CHANNELS    = 128;

    localparam logic [CFG_W-1:0] DWELL_RST    = 16'd100;
    localparam logic [CFG_W-1:0] COOLDOWN_RST = 16'd2000;
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd200;
    localparam logic [CNT_W-1:0] CHCOUNT_RST  = 8'd126;

    typedef enum logic [IDX_W-1:0] {
        CFG_HOP_DWELL = 2'd0,
        CFG_COOLDOWN  = 2'd1,
        CFG_DEBOUNCE  = 2'd2,
        CFG_CH_COUNT  = 2'd3
    } cfg_idx_t;

    // one poll after the button and hop logic, headed for the hit table stage
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              carrier_seen;
        logic [CH_W-1:0]   sampled;
        logic              retune;
        logic [CH_W-1:0]   tune_channel;
        logic              hopping;
    } poll_t;

endpackage

FILE: rtl/core/cshl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cshl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cshl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/cshl_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cshl_scan
// Configuration registers, button toggle latch/debounce and auto-hop channel
// sequencing; produces one poll record per transfer.
// ----------------------------------------------------------------------------
module cshl_scan import cshl_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              accept,
    input  logic [TIME_W-1:0] now_ms,
    input  logic              carrier_seen,
    input  logic              button_down,
    output logic [CFG_W-1:0]  cooldown_ms,
    output poll_t             poll
);

    localparam int CAP = (TABLE_DEPTH < MAX_CHANNELS) ? TABLE_DEPTH : MAX_CHANNELS;
    localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAP);

    logic [CFG_W-1:0]  dwell_reg, cooldown_reg, debounce_reg;
    logic [CNT_W-1:0]  ch_count_reg;
    logic [CH_W-1:0]   cur_ch_reg, cur_ch_next;
    logic              auto_hop_reg, auto_hop_next;
    logic              rel_latch_reg, rel_latch_next;
    logic [TIME_W-1:0] toggle_time_reg, toggle_time_next;
    logic [TIME_W-1:0] hop_time_reg, hop_time_next;

    logic [CNT_W-1:0]  eff_count;
    logic [CNT_W-1:0]  next_ch;
    logic [TIME_W-1:0] since_toggle, since_hop;
    logic              hop;

    always_comb begin
        if (ch_count_reg == '0) begin
            eff_count = CNT_W'(1);
        end else if (ch_count_reg > CAP_V) begin
            eff_count = CAP_V;
        end else begin
            eff_count = ch_count_reg;
        end
        next_ch = {1'b0, cur_ch_reg} + CNT_W'(1);
        if (next_ch >= eff_count) begin
            next_ch = '0;
        end
    end

    assign since_toggle = now_ms - toggle_time_reg;
    assign since_hop    = now_ms - hop_time_reg;

    always_comb begin
        rel_latch_next   = rel_latch_reg;
        auto_hop_next    = auto_hop_reg;
        toggle_time_next = toggle_time_reg;
        hop_time_next    = hop_time_reg;
        cur_ch_next      = cur_ch_reg;
        if (rel_latch_reg) begin
            if (!button_down) begin
                rel_latch_next = 1'b0;
            end
        end else if (button_down && since_toggle > {16'd0, debounce_reg}) begin
            auto_hop_next    = !auto_hop_reg;
            toggle_time_next = now_ms;
            rel_latch_next   = 1'b1;
        end
        hop = auto_hop_next && (since_hop >= {16'd0, dwell_reg});
        if (hop) begin
            cur_ch_next   = next_ch[CH_W-1:0];
            hop_time_next = now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dwell_reg       <= DWELL_RST;
            cooldown_reg    <= COOLDOWN_RST;
            debounce_reg    <= DEBOUNCE_RST;
            ch_count_reg    <= CHCOUNT_RST;
            cur_ch_reg      <= '0;
            auto_hop_reg    <= 1'b1;
            rel_latch_reg   <= 1'b1;
            toggle_time_reg <= '0;
            hop_time_reg    <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_HOP_DWELL: dwell_reg    <= cfg_data;
                    CFG_COOLDOWN:  cooldown_reg <= cfg_data;
                    CFG_DEBOUNCE:  debounce_reg <= cfg_data;
                    CFG_CH_COUNT:  ch_count_reg <= cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                cur_ch_reg      <= cur_ch_next;
                auto_hop_reg    <= auto_hop_next;
                rel_latch_reg   <= rel_latch_next;
                toggle_time_reg <= toggle_time_next;
                hop_time_reg    <= hop_time_next;
            end
        end
    end

    assign cooldown_ms = cooldown_reg;

    always_comb begin
        poll.now_ms       = now_ms;
        poll.carrier_seen = carrier_seen;
        poll.sampled      = cur_ch_reg;
        poll.retune       = hop;
        poll.tune_channel = cur_ch_next;
        poll.hopping      = auto_hop_next;
    end

endmodule

FILE: rtl/core/cshl_log.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cshl_log
// Per-channel last-hit table: read on transfer, cooldown check and write-back
// from the registered table stage, hit counter and result register.
// ----------------------------------------------------------------------------
module cshl_log import cshl_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  poll_t             poll,
    input  logic [CFG_W-1:0]  cooldown_ms,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_hit_valid,
    output logic [CH_W-1:0]   m_hit_channel,
    output logic              m_retune,
    output logic [CH_W-1:0]   m_tune_channel,
    output logic              m_hopping,
    output logic [TIME_W-1:0] m_hit_count
);

    localparam int AW = $clog2(TABLE_DEPTH);

    // stage 1
    logic              st1_valid_reg;
    poll_t             st1_poll_reg;
    logic [AW-1:0]     st1_slot_reg;
    logic              st1_vld_reg;
    logic              st1_fwd_reg;
    logic [TIME_W-1:0] st1_fwd_data_reg;

    logic [TABLE_DEPTH-1:0] entry_vld_reg;
    logic [TIME_W-1:0]      total_reg;

    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [CH_W-1:0]   out_hit_ch_reg;
    logic              out_retune_reg;
    logic [CH_W-1:0]   out_tune_reg;
    logic              out_hopping_reg;

    logic              out_free, st1_fire, hit, wr_en;
    logic [AW-1:0]     req_slot;
    logic [TIME_W-1:0] rd_data, last_hit;
    logic [TIME_W-1:0] total_next;

    // current channel always stays below the table depth
    assign req_slot = AW'(poll.sampled);

    assign out_free = !out_valid_reg || m_ready;
    assign st1_fire = st1_valid_reg && out_free;
    assign s_ready  = !st1_valid_reg || out_free;

    always_comb begin
        if (st1_fwd_reg) begin
            last_hit = st1_fwd_data_reg;
        end else if (st1_vld_reg) begin
            last_hit = rd_data;
        end else begin
            last_hit = '0;
        end
    end

    assign hit        = st1_poll_reg.carrier_seen &&
                        ((st1_poll_reg.now_ms - last_hit) >= {16'd0, cooldown_ms});
    assign wr_en      = st1_fire && hit;
    assign total_next = total_reg + TIME_W'(1);

    cshl_ram #(
        .WIDTH (TIME_W),
        .DEPTH (TABLE_DEPTH)
    ) u_hit_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (st1_slot_reg),
        .wr_data (st1_poll_reg.now_ms),
        .rd_en   (accept),
        .rd_addr (req_slot),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            entry_vld_reg <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                st1_valid_reg <= 1'b1;
            end else if (st1_fire) begin
                st1_valid_reg <= 1'b0;
            end
            if (wr_en) begin
                entry_vld_reg[st1_slot_reg] <= 1'b1;
                total_reg                   <= total_next;
            end
            if (st1_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_poll_reg     <= poll;
            st1_slot_reg     <= req_slot;
            st1_vld_reg      <= entry_vld_reg[req_slot];
            st1_fwd_reg      <= wr_en && (st1_slot_reg == req_slot);
            st1_fwd_data_reg <= st1_poll_reg.now_ms;
        end
        if (st1_fire) begin
            out_hit_reg     <= hit;
            out_hit_ch_reg  <= hit ? st1_poll_reg.sampled : '0;
            out_retune_reg  <= st1_poll_reg.retune;
            out_tune_reg    <= st1_poll_reg.tune_channel;
            out_hopping_reg <= st1_poll_reg.hopping;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_hit_valid    = out_hit_reg;
    assign m_hit_channel  = out_hit_ch_reg;
    assign m_retune       = out_retune_reg;
    assign m_tune_channel = out_tune_reg;
    assign m_hopping      = out_hopping_reg;
    assign m_hit_count    = total_reg;

    a_fwd_source: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !st1_fwd_reg || $past(wr_en))
        else $error("forward flag without a write-back");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> total_reg == $past(total_next))
        else $error("hit count did not advance on a hit");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !wr_en |=> $stable(total_reg))
        else $error("hit count changed without a hit");

    a_no_hit_ch: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_hit_reg |-> out_hit_ch_reg == '0)
        else $error("hit channel set without a hit");

    a_stall_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && !out_free |=> st1_valid_reg)
        else $error("stalled poll dropped");

endmodule

FILE: rtl/core/channel_scan_hit_logger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_scan_hit_logger
// Channel scan sequencer with per-channel hit cooldown and hit counting.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | now_ms, carrier_seen, button_down
//   m_      | out       | m_valid / m_ready  | hit_valid, hit_channel, retune,
//           |           |                    | tune_channel, hopping, hit_count
//   cfg_    | in        | cfg_we             | cfg_index, cfg_data
//
// One poll per cycle sustained while m_ready stays high. The table read is issued
// at the input transfer; cooldown check and write-back happen from the registered
// table stage, at the edge that loads the result register behind m_valid.
// Back-to-back hits on one channel are forwarded.
// Reset clears the table valid bits at once; no clearing pass.
// A stalled result holds the table stage; s_ready drops only when both are full
// and m_ready is low.
// ----------------------------------------------------------------------------
module channel_scan_hit_logger import cshl_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [TIME_W-1:0] s_now_ms,
    input  logic              s_carrier_seen,
    input  logic              s_button_down,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_hit_valid,
    output logic [CH_W-1:0]   m_hit_channel,
    output logic              m_retune,
    output logic [CH_W-1:0]   m_tune_channel,
    output logic              m_hopping,
    output logic [TIME_W-1:0] m_hit_count
);

    logic             accept;
    logic [CFG_W-1:0] cooldown_ms;
    poll_t            poll;

    assign accept = s_valid && s_ready;

    cshl_scan #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .now_ms       (s_now_ms),
        .carrier_seen (s_carrier_seen),
        .button_down  (s_button_down),
        .cooldown_ms  (cooldown_ms),
        .poll         (poll)
    );

    cshl_log #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_log (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .poll           (poll),
        .cooldown_ms    (cooldown_ms),
        .s_ready        (s_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit_valid    (m_hit_valid),
        .m_hit_channel  (m_hit_channel),
        .m_retune       (m_retune),
        .m_tune_channel (m_tune_channel),
        .m_hopping      (m_hopping),
        .m_hit_count    (m_hit_count)
    );

endmodule
